### src/evade_steering_force_top_defines.svh
// Assertion macros shared by the evade steering force RTL.
`ifndef EVADE_STEERING_FORCE_TOP_DEFINES_SVH
`define EVADE_STEERING_FORCE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define EVSF_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("evade steering force: implication check failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define EVSF_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("evade steering force: next-cycle check failed");

`endif

### src/evsf_pkg.sv
// Package with shared constants and helpers for the evade steering force block.
`timescale 1ns / 1ps
package evsf_pkg;

    localparam int DATA_W        = 32;
    localparam int SPEED_W       = 31;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 31'd65536;

    // Clamp a 34-bit signed value to the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [33:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 34'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -34'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/evsf_isqrt.sv
// Pipelined floor integer square root, one result bit per register stage.
`timescale 1ns / 1ps
module evsf_isqrt #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vld_in,
    input  logic [IN_W-1:0]     v_in,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                vld_out,
    output logic [IN_W/2-1:0]   root,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int N = IN_W / 2;

    logic [IN_W-1:0]   v_reg    [N];
    logic [IN_W-1:0]   r_reg    [N];
    logic [SIDE_W-1:0] side_reg [N];
    logic              vld_reg  [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        localparam logic [IN_W-1:0] BIT = {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2 * k);

        logic [IN_W-1:0]   v_prev;
        logic [IN_W-1:0]   r_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              vld_prev;
        logic [IN_W-1:0]   rb;
        logic [IN_W-1:0]   v_next;
        logic [IN_W-1:0]   r_next;

        if (k == 0)
        begin : g_first
            assign v_prev    = v_in;
            assign r_prev    = '0;
            assign side_prev = side_in;
            assign vld_prev  = vld_in;
        end
        else
        begin : g_rest
            assign v_prev    = v_reg[k-1];
            assign r_prev    = r_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        always_comb
        begin
            rb = r_prev + BIT;
            if (v_prev >= rb)
            begin
                v_next = v_prev - rb;
                r_next = (r_prev >> 1) + BIT;
            end
            else
            begin
                v_next = v_prev;
                r_next = r_prev >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            v_reg[k]    <= v_next;
            r_reg[k]    <= r_next;
            side_reg[k] <= side_prev;
        end
    end

    assign vld_out  = vld_reg[N-1];
    assign root     = r_reg[N-1][N-1:0];
    assign side_out = side_reg[N-1];

endmodule

### src/evsf_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module evsf_div #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vld_in,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output logic [Q_W-1:0]    quot,
    output logic [SIDE_W-1:0] side_out
);

    // The caller guarantees num < den * 2^Q_W, so the remainder fits in W bits.
    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [W-1:0]      rem_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic              vld_reg  [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        localparam int SH = Q_W - 1 - k;
        localparam logic [Q_W-1:0] QBIT = {{(Q_W-1){1'b0}}, 1'b1} << SH;

        logic [W-1:0]      rem_prev;
        logic [Q_W-1:0]    q_prev;
        logic [DEN_W-1:0]  den_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              vld_prev;
        logic [W-1:0]      dsh;
        logic [W-1:0]      rem_next;
        logic [Q_W-1:0]    q_next;

        if (k == 0)
        begin : g_first
            assign rem_prev  = W'(num);
            assign q_prev    = '0;
            assign den_prev  = den;
            assign side_prev = side_in;
            assign vld_prev  = vld_in;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign q_prev    = q_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        always_comb
        begin
            dsh = W'(den_prev) << SH;
            if (rem_prev >= dsh)
            begin
                rem_next = rem_prev - dsh;
                q_next   = q_prev | QBIT;
            end
            else
            begin
                rem_next = rem_prev;
                q_next   = q_prev;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            q_reg[k]    <= q_next;
            den_reg[k]  <= den_prev;
            side_reg[k] <= side_prev;
        end
    end

    assign vld_out  = vld_reg[Q_W-1];
    assign quot     = q_reg[Q_W-1];
    assign side_out = side_reg[Q_W-1];

endmodule

### src/evade_steering_force_top.sv
// Top level of the evade steering force pipeline.
//
// Usage: raise start with the target flag, agent and target positions and
// velocities (signed fixed point, FRAC_BITS fraction bits). busy is always
// low, so a transaction is taken on every clock edge at which start is high.
// max_speed is written through cfg_we/cfg_data; the user must write it only
// while no transaction is in flight (the block does not enforce this); it resets to 1.0.
// Each transaction produces one result: force_x, force_y and success are
// shown for one cycle with done high. Throughput is one transaction per
// cycle. The pipeline is made of the two square root pipelines (32 stages
// each), the look-ahead divider (32 stages), the direction scaling dividers
// (31 stages) and ten single stages.
// The receiver cannot stall; results are presented once and never held.
// Reset clears every valid bit, so no result appears until new input comes.
`timescale 1ns / 1ps
`include "evade_steering_force_top_defines.svh"
module evade_steering_force_top #(
    parameter int FRAC_BITS = evsf_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    cfg_we,
    input  logic [evsf_pkg::SPEED_W-1:0]            cfg_data,
    input  logic                                    target_present,
    input  logic signed [evsf_pkg::DATA_W-1:0]      agent_pos_x,
    input  logic signed [evsf_pkg::DATA_W-1:0]      agent_pos_y,
    input  logic signed [evsf_pkg::DATA_W-1:0]      target_pos_x,
    input  logic signed [evsf_pkg::DATA_W-1:0]      target_pos_y,
    input  logic signed [evsf_pkg::DATA_W-1:0]      agent_vel_x,
    input  logic signed [evsf_pkg::DATA_W-1:0]      agent_vel_y,
    input  logic signed [evsf_pkg::DATA_W-1:0]      target_vel_x,
    input  logic signed [evsf_pkg::DATA_W-1:0]      target_vel_y,
    output logic                                    done,
    output logic signed [evsf_pkg::DATA_W-1:0]      force_x,
    output logic signed [evsf_pkg::DATA_W-1:0]      force_y,
    output logic                                    success
);

    import evsf_pkg::*;

    localparam int NUM1_W = 34 + FRAC_BITS;
    localparam int DIV1_W = (NUM1_W > 63) ? NUM1_W : 63;

    typedef struct packed {
        logic              tp;
        logic [1:0]        sh;
        logic signed [32:0] ex0x;
        logic signed [32:0] ex0y;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] tvx;
        logic signed [31:0] tvy;
    } sq1_side_t;

    typedef struct packed {
        logic              tp;
        logic              sat;
        logic signed [32:0] ex0x;
        logic signed [32:0] ex0y;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] tvx;
        logic signed [31:0] tvy;
    } div1_side_t;

    typedef struct packed {
        logic              tp;
        logic              nz;
        logic              sgnx;
        logic              sgny;
        logic [61:0]       px;
        logic [61:0]       py;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
    } sq2_side_t;

    typedef struct packed {
        logic              tp;
        logic              nz;
        logic              sgnx;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
    } divx_side_t;

    // Configuration register.
    logic [SPEED_W-1:0] ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg <= MAX_SPEED_RST;
        end
        else if (cfg_we)
        begin
            ms_reg <= cfg_data;
        end
    end

    assign busy = 1'b0;

    // Stage 0: input register.
    logic              s0_vld_reg;
    logic              s0_tp_reg;
    logic signed [31:0] s0_ax_reg, s0_ay_reg, s0_tx_reg, s0_ty_reg;
    logic signed [31:0] s0_avx_reg, s0_avy_reg, s0_tvx_reg, s0_tvy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_tp_reg  <= target_present;
        s0_ax_reg  <= agent_pos_x;
        s0_ay_reg  <= agent_pos_y;
        s0_tx_reg  <= target_pos_x;
        s0_ty_reg  <= target_pos_y;
        s0_avx_reg <= agent_vel_x;
        s0_avy_reg <= agent_vel_y;
        s0_tvx_reg <= target_vel_x;
        s0_tvy_reg <= target_vel_y;
    end

    // Stage 1: offset to the target and range reduction for the distance.
    logic signed [32:0] ex0x_next, ex0y_next;
    logic [32:0]        m1x, m1y, m1or;
    logic [1:0]         sh1_next;
    logic [30:0]        r1x_next, r1y_next;

    always_comb
    begin
        ex0x_next = 33'(s0_ax_reg) - 33'(s0_tx_reg);
        ex0y_next = 33'(s0_ay_reg) - 33'(s0_ty_reg);
        m1x = ex0x_next[32] ? 33'(-ex0x_next) : 33'(ex0x_next);
        m1y = ex0y_next[32] ? 33'(-ex0y_next) : 33'(ex0y_next);
        m1or = m1x | m1y;
        if (m1or[32])
        begin
            sh1_next = 2'd2;
        end
        else if (m1or[31])
        begin
            sh1_next = 2'd1;
        end
        else
        begin
            sh1_next = 2'd0;
        end
        r1x_next = 31'(m1x >> sh1_next);
        r1y_next = 31'(m1y >> sh1_next);
    end

    logic        s1_vld_reg;
    logic [30:0] s1_rx_reg, s1_ry_reg;
    sq1_side_t   s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rx_reg        <= r1x_next;
        s1_ry_reg        <= r1y_next;
        s1_side_reg.tp   <= s0_tp_reg;
        s1_side_reg.sh   <= sh1_next;
        s1_side_reg.ex0x <= ex0x_next;
        s1_side_reg.ex0y <= ex0y_next;
        s1_side_reg.avx  <= s0_avx_reg;
        s1_side_reg.avy  <= s0_avy_reg;
        s1_side_reg.tvx  <= s0_tvx_reg;
        s1_side_reg.tvy  <= s0_tvy_reg;
    end

    // Stage 2: sum of squares.
    logic [61:0] sq1x, sq1y;
    logic        s2_vld_reg;
    logic [63:0] s2_sq_reg;
    sq1_side_t   s2_side_reg;

    always_comb
    begin
        sq1x = s1_rx_reg * s1_rx_reg;
        sq1y = s1_ry_reg * s1_ry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_sq_reg   <= 64'(sq1x) + 64'(sq1y);
        s2_side_reg <= s1_side_reg;
    end

    // Distance square root.
    logic                     q1_vld;
    logic [31:0]              q1_root;
    logic [$bits(sq1_side_t)-1:0] q1_side_bits;
    sq1_side_t                q1_side;

    evsf_isqrt #(
        .IN_W   (64),
        .SIDE_W ($bits(sq1_side_t))
    ) u_sqrt_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (s2_vld_reg),
        .v_in     (s2_sq_reg),
        .side_in  (s2_side_reg),
        .vld_out  (q1_vld),
        .root     (q1_root),
        .side_out (q1_side_bits)
    );

    assign q1_side = sq1_side_t'(q1_side_bits);

    // Stage 3: scaled distance and look-ahead saturation check.
    logic [33:0]       len1;
    logic [DIV1_W-1:0] num1_wide;
    logic              sat1_next;

    always_comb
    begin
        len1      = 34'(q1_root) << q1_side.sh;
        num1_wide = DIV1_W'(len1) << FRAC_BITS;
        sat1_next = num1_wide >= (DIV1_W'(ms_reg) << 32);
    end

    logic              s3_vld_reg;
    logic [NUM1_W-1:0] s3_num_reg;
    div1_side_t        s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= q1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_num_reg       <= NUM1_W'(num1_wide);
        s3_side_reg.tp   <= q1_side.tp;
        s3_side_reg.sat  <= sat1_next;
        s3_side_reg.ex0x <= q1_side.ex0x;
        s3_side_reg.ex0y <= q1_side.ex0y;
        s3_side_reg.avx  <= q1_side.avx;
        s3_side_reg.avy  <= q1_side.avy;
        s3_side_reg.tvx  <= q1_side.tvx;
        s3_side_reg.tvy  <= q1_side.tvy;
    end

    // Look-ahead divider.
    logic                          d1_vld;
    logic [31:0]                   d1_quot;
    logic [$bits(div1_side_t)-1:0] d1_side_bits;
    div1_side_t                    d1_side;

    evsf_div #(
        .NUM_W  (NUM1_W),
        .DEN_W  (SPEED_W),
        .Q_W    (32),
        .SIDE_W ($bits(div1_side_t))
    ) u_div_ahead (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (s3_vld_reg),
        .num      (s3_num_reg),
        .den      (ms_reg),
        .side_in  (s3_side_reg),
        .vld_out  (d1_vld),
        .quot     (d1_quot),
        .side_out (d1_side_bits)
    );

    assign d1_side = div1_side_t'(d1_side_bits);

    // Stage 4: target velocity times look-ahead.
    logic [31:0] ahead, tvmx, tvmy;
    logic [63:0] prodx, prody;

    always_comb
    begin
        ahead = d1_side.sat ? '1 : d1_quot;
        tvmx  = d1_side.tvx[31] ? 32'(-d1_side.tvx) : 32'(d1_side.tvx);
        tvmy  = d1_side.tvy[31] ? 32'(-d1_side.tvy) : 32'(d1_side.tvy);
        prodx = tvmx * ahead;
        prody = tvmy * ahead;
    end

    logic               s4_vld_reg;
    logic [63:0]        s4_prodx_reg, s4_prody_reg;
    logic               s4_sgnx_reg, s4_sgny_reg, s4_tp_reg;
    logic signed [32:0] s4_ex0x_reg, s4_ex0y_reg;
    logic signed [31:0] s4_avx_reg, s4_avy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s4_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_prodx_reg <= prodx;
        s4_prody_reg <= prody;
        s4_sgnx_reg  <= d1_side.tvx[31];
        s4_sgny_reg  <= d1_side.tvy[31];
        s4_tp_reg    <= d1_side.tp;
        s4_ex0x_reg  <= d1_side.ex0x;
        s4_ex0y_reg  <= d1_side.ex0y;
        s4_avx_reg   <= d1_side.avx;
        s4_avy_reg   <= d1_side.avy;
    end

    // Stage 5: direction away from the predicted target position.
    logic signed [65:0] offx, offy, ex_next, ey_next;

    always_comb
    begin
        offx = $signed({2'b00, s4_prodx_reg >> FRAC_BITS});
        offy = $signed({2'b00, s4_prody_reg >> FRAC_BITS});
        if (s4_sgnx_reg)
        begin
            offx = -offx;
        end
        if (s4_sgny_reg)
        begin
            offy = -offy;
        end
        ex_next = 66'(s4_ex0x_reg) - offx;
        ey_next = 66'(s4_ex0y_reg) - offy;
    end

    logic               s5_vld_reg, s5_tp_reg;
    logic signed [65:0] s5_ex_reg, s5_ey_reg;
    logic signed [31:0] s5_avx_reg, s5_avy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_ex_reg  <= ex_next;
        s5_ey_reg  <= ey_next;
        s5_tp_reg  <= s4_tp_reg;
        s5_avx_reg <= s4_avx_reg;
        s5_avy_reg <= s4_avy_reg;
    end

    // Stage 6: magnitudes and the reduction shift.
    logic [64:0] m6x, m6y, m6or;
    logic [6:0]  msb6, sh6_next;

    always_comb
    begin
        m6x  = s5_ex_reg[65] ? 65'(-s5_ex_reg) : 65'(s5_ex_reg);
        m6y  = s5_ey_reg[65] ? 65'(-s5_ey_reg) : 65'(s5_ey_reg);
        m6or = m6x | m6y;
        msb6 = '0;
        for (int i = 0; i < 65; i++)
        begin
            if (m6or[i])
            begin
                msb6 = 7'(i);
            end
        end
        sh6_next = (msb6 > 7'd30) ? msb6 - 7'd30 : 7'd0;
    end

    logic               s6_vld_reg, s6_tp_reg, s6_nz_reg, s6_sgnx_reg, s6_sgny_reg;
    logic [64:0]        s6_mx_reg, s6_my_reg;
    logic [6:0]         s6_sh_reg;
    logic signed [31:0] s6_avx_reg, s6_avy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_vld_reg <= 1'b0;
        end
        else
        begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_mx_reg   <= m6x;
        s6_my_reg   <= m6y;
        s6_sh_reg   <= sh6_next;
        s6_nz_reg   <= |m6or;
        s6_sgnx_reg <= s5_ex_reg[65];
        s6_sgny_reg <= s5_ey_reg[65];
        s6_tp_reg   <= s5_tp_reg;
        s6_avx_reg  <= s5_avx_reg;
        s6_avy_reg  <= s5_avy_reg;
    end

    // Stage 7: reduced direction components.
    logic               s7_vld_reg, s7_tp_reg, s7_nz_reg, s7_sgnx_reg, s7_sgny_reg;
    logic [30:0]        s7_rx_reg, s7_ry_reg;
    logic signed [31:0] s7_avx_reg, s7_avy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_vld_reg <= 1'b0;
        end
        else
        begin
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_rx_reg   <= 31'(s6_mx_reg >> s6_sh_reg);
        s7_ry_reg   <= 31'(s6_my_reg >> s6_sh_reg);
        s7_nz_reg   <= s6_nz_reg;
        s7_sgnx_reg <= s6_sgnx_reg;
        s7_sgny_reg <= s6_sgny_reg;
        s7_tp_reg   <= s6_tp_reg;
        s7_avx_reg  <= s6_avx_reg;
        s7_avy_reg  <= s6_avy_reg;
    end

    // Stage 8: direction length squared and speed-scaled numerators.
    logic [61:0] sq2x, sq2y, px_next, py_next;

    always_comb
    begin
        sq2x    = s7_rx_reg * s7_rx_reg;
        sq2y    = s7_ry_reg * s7_ry_reg;
        px_next = s7_rx_reg * ms_reg;
        py_next = s7_ry_reg * ms_reg;
    end

    logic        s8_vld_reg;
    logic [63:0] s8_sq_reg;
    sq2_side_t   s8_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_vld_reg <= 1'b0;
        end
        else
        begin
            s8_vld_reg <= s7_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s8_sq_reg        <= 64'(sq2x) + 64'(sq2y);
        s8_side_reg.tp   <= s7_tp_reg;
        s8_side_reg.nz   <= s7_nz_reg;
        s8_side_reg.sgnx <= s7_sgnx_reg;
        s8_side_reg.sgny <= s7_sgny_reg;
        s8_side_reg.px   <= px_next;
        s8_side_reg.py   <= py_next;
        s8_side_reg.avx  <= s7_avx_reg;
        s8_side_reg.avy  <= s7_avy_reg;
    end

    // Direction length square root.
    logic                         q2_vld;
    logic [31:0]                  q2_root;
    logic [$bits(sq2_side_t)-1:0] q2_side_bits;
    sq2_side_t                    q2_side;
    logic [31:0]                  dir_len;
    divx_side_t                   dx_side_in;

    evsf_isqrt #(
        .IN_W   (64),
        .SIDE_W ($bits(sq2_side_t))
    ) u_sqrt_dir (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (s8_vld_reg),
        .v_in     (s8_sq_reg),
        .side_in  (s8_side_reg),
        .vld_out  (q2_vld),
        .root     (q2_root),
        .side_out (q2_side_bits)
    );

    always_comb
    begin
        q2_side         = sq2_side_t'(q2_side_bits);
        dir_len         = (q2_root == '0) ? 32'd1 : q2_root;
        dx_side_in.tp   = q2_side.tp;
        dx_side_in.nz   = q2_side.nz;
        dx_side_in.sgnx = q2_side.sgnx;
        dx_side_in.avx  = q2_side.avx;
        dx_side_in.avy  = q2_side.avy;
    end

    // Per-axis scaling dividers; the quotient never exceeds max_speed.
    logic                          dvx_vld, dvy_vld;
    logic [30:0]                   qx, qy;
    logic [$bits(divx_side_t)-1:0] dx_side_bits;
    divx_side_t                    dx_side;
    logic                          dy_sgn;

    evsf_div #(
        .NUM_W  (62),
        .DEN_W  (32),
        .Q_W    (31),
        .SIDE_W ($bits(divx_side_t))
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (q2_vld),
        .num      (q2_side.px),
        .den      (dir_len),
        .side_in  (dx_side_in),
        .vld_out  (dvx_vld),
        .quot     (qx),
        .side_out (dx_side_bits)
    );

    evsf_div #(
        .NUM_W  (62),
        .DEN_W  (32),
        .Q_W    (31),
        .SIDE_W (1)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (q2_vld),
        .num      (q2_side.py),
        .den      (dir_len),
        .side_in  (q2_side.sgny),
        .vld_out  (dvy_vld),
        .quot     (qy),
        .side_out (dy_sgn)
    );

    assign dx_side = divx_side_t'(dx_side_bits);

    // Output stage: desired minus agent velocity, saturated; zero when no target is present.
    logic signed [33:0] dvx, dvy, fx, fy;

    always_comb
    begin
        dvx = $signed({3'b000, qx});
        dvy = $signed({3'b000, qy});
        if (dx_side.sgnx)
        begin
            dvx = -dvx;
        end
        if (dy_sgn)
        begin
            dvy = -dvy;
        end
        if (!dx_side.nz)
        begin
            dvx = '0;
            dvy = '0;
        end
        fx = dvx - 34'(dx_side.avx);
        fy = dvy - 34'(dx_side.avy);
    end

    logic              done_reg, success_reg;
    logic signed [31:0] force_x_reg, force_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dvx_vld & dvy_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        success_reg <= dx_side.tp;
        force_x_reg <= dx_side.tp ? sat32(fx) : '0;
        force_y_reg <= dx_side.tp ? sat32(fy) : '0;
    end

    assign done    = done_reg;
    assign success = success_reg;
    assign force_x = force_x_reg;
    assign force_y = force_y_reg;

    // A nonzero direction keeps a nonzero reduced component, so its length is never zero.
    `EVSF_ASSERT_IMP(a_reduced_nonzero, s7_vld_reg && s7_nz_reg, s7_rx_reg != '0 || s7_ry_reg != '0)
    `EVSF_ASSERT_IMP(a_dir_len_nonzero, q2_vld && q2_side.nz, q2_root != '0)
    `EVSF_ASSERT_NXT(a_fail_zero_force, dvx_vld && !dx_side.tp, done && !success && force_x == '0 && force_y == '0)

endmodule
